>>> src/abic_pkg.sv
// ----------------------------------------------------------------------------
// abic_pkg: shared constants for the audio band-pass IIR cascade
// Widths of the state word and coefficients, register indexes and reset values.
// ----------------------------------------------------------------------------
package abic_pkg;

	localparam int STATE_W   = 48;
	localparam int COEF_W    = 32;
	localparam int FRAC_BITS = 12;
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_HP_GAIN       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HP_POLE       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_GAIN    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_FB_ONE  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_FB_TWO  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_GAIN   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_FB_ONE = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_FB_TWO = 3'd7;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [STATE_W-1:0] state_word_t;

	localparam coef_t COEF_RESET [NUM_REGS] = '{
		32'sd1072127937, 32'sd1072125520, 32'sd4091094, -32'sd1900221824,
		32'sd842855000, 32'sd4366050, -32'sd2027944824, 32'sd971660000
	};

endpackage

>>> src/audio_bandpass_iir_cascade.sv
// ----------------------------------------------------------------------------
// audio_bandpass_iir_cascade: two DC high-pass stages and two low-pass biquads
// Each item makes ten passes through the shared multiplier plus the add steps
// of the sequencer; a stalled master side holds the sequencer in its round step.
// The input side is ready only while the sequencer is idle.
// Reset clears all filter state and loads the default coefficients.
// ----------------------------------------------------------------------------
module audio_bandpass_iir_cascade #(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // sample_in
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,  // sample_out
	input  logic                                  cfg_we,
	input  logic [abic_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [abic_pkg::COEF_W-1:0]           cfg_data
);

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int SW     = abic_pkg::STATE_W;
	localparam int FB     = abic_pkg::FRAC_BITS;
	localparam int RTOP   = FB + SAMPLE_BITS - 1;

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b0000000001,
		ST_HP_POLE = 10'b0000000010,
		ST_HP_GAIN = 10'b0000000100,
		ST_HP_DIFF = 10'b0000001000,
		ST_BQ_FB2  = 10'b0000010000,
		ST_BQ_FB1  = 10'b0000100000,
		ST_BQ_W    = 10'b0001000000,
		ST_BQ_SUM  = 10'b0010000000,
		ST_BQ_GAIN = 10'b0100000000,
		ST_ROUND   = 10'b1000000000
	} seq_state_t;

	function automatic abic_pkg::state_word_t sat_state(input logic signed [SW+3:0] v);
		if ((&v[SW+3:SW-1]) || !(|v[SW+3:SW-1])) begin
			return v[SW-1:0];
		end else if (v[SW+3]) begin
			return {1'b1, {(SW-1){1'b0}}};
		end else begin
			return {1'b0, {(SW-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [SW+3:0] ext(input abic_pkg::state_word_t v);
		return {{4{v[SW-1]}}, v};
	endfunction

	seq_state_t            state_q;
	logic                  idx_q;
	logic                  mul_wait_q;
	logic                  mul_start;
	logic                  mul_done;
	abic_pkg::state_word_t mul_a;
	abic_pkg::coef_t       mul_c;
	abic_pkg::state_word_t mul_res;

	abic_pkg::coef_t       coef_q [abic_pkg::NUM_REGS];
	abic_pkg::state_word_t prev_q;
	abic_pkg::state_word_t hp_prev_q [2];
	abic_pkg::state_word_t dl_q [2][2];
	abic_pkg::state_word_t diff_q;
	abic_pkg::state_word_t t_q;
	abic_pkg::state_word_t s_q;
	logic                  out_valid_q;
	logic [SAMPLE_BITS-1:0] out_q;

	abic_pkg::state_word_t x_in;
	logic signed [SW:0]    rnd;
	logic [SAMPLE_BITS-1:0] rnd_sat;
	logic                  in_take;
	logic                  out_load;

	assign x_in = {{(SW-FB-SAMPLE_BITS){s_axis_tdata[SAMPLE_BITS-1]}},
		s_axis_tdata[SAMPLE_BITS-1:0], {FB{1'b0}}};

	assign rnd = {s_q[SW-1], s_q} + {{(SW+1-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

	always_comb begin
		if (rnd[SW:RTOP] == {(SW+1-RTOP){rnd[SW]}}) begin
			rnd_sat = rnd[RTOP:FB];
		end else if (rnd[SW]) begin
			rnd_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			rnd_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_ROUND) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(DATA_W-SAMPLE_BITS){1'b0}}, out_q};

	always_comb begin
		mul_start = 1'b0;
		mul_a     = t_q;
		mul_c     = coef_q[abic_pkg::REG_HP_GAIN];
		unique case (state_q)
			ST_HP_POLE: begin
				mul_start = !mul_wait_q;
				mul_a     = hp_prev_q[idx_q];
				mul_c     = coef_q[abic_pkg::REG_HP_POLE];
			end
			ST_HP_GAIN: begin
				mul_start = !mul_wait_q;
			end
			ST_BQ_FB2: begin
				mul_start = !mul_wait_q;
				mul_a     = dl_q[idx_q][1];
				mul_c     = idx_q ? coef_q[abic_pkg::REG_SECOND_FB_TWO]
					: coef_q[abic_pkg::REG_FIRST_FB_TWO];
			end
			ST_BQ_FB1: begin
				mul_start = !mul_wait_q;
				mul_a     = dl_q[idx_q][0];
				mul_c     = idx_q ? coef_q[abic_pkg::REG_SECOND_FB_ONE]
					: coef_q[abic_pkg::REG_FIRST_FB_ONE];
			end
			ST_BQ_GAIN: begin
				mul_start = !mul_wait_q;
				mul_c     = idx_q ? coef_q[abic_pkg::REG_SECOND_GAIN]
					: coef_q[abic_pkg::REG_FIRST_GAIN];
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	abic_mulq #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_mulq (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.c(mul_c),
		.done(mul_done),
		.result(mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= 1'b0;
			mul_wait_q  <= 1'b0;
			out_valid_q <= 1'b0;
			prev_q      <= '0;
			diff_q      <= '0;
			t_q         <= '0;
			s_q         <= '0;
			for (int i = 0; i < 2; i++) begin
				hp_prev_q[i] <= '0;
				dl_q[i][0]   <= '0;
				dl_q[i][1]   <= '0;
			end
			for (int i = 0; i < abic_pkg::NUM_REGS; i++) begin
				coef_q[i] <= abic_pkg::COEF_RESET[i];
			end
		end else begin
			if (cfg_we) begin
				coef_q[cfg_index] <= cfg_data;
			end
			if (mul_start) begin
				mul_wait_q <= 1'b1;
			end else if (mul_done) begin
				mul_wait_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						diff_q  <= sat_state(ext(x_in) - ext(prev_q));
						prev_q  <= x_in;
						idx_q   <= 1'b0;
						state_q <= ST_HP_POLE;
					end
				end
				ST_HP_POLE: begin
					if (mul_done) begin
						t_q     <= sat_state(ext(diff_q) + ext(mul_res));
						state_q <= ST_HP_GAIN;
					end
				end
				ST_HP_GAIN: begin
					if (mul_done) begin
						s_q     <= mul_res;
						state_q <= ST_HP_DIFF;
					end
				end
				ST_HP_DIFF: begin
					diff_q           <= sat_state(ext(s_q) - ext(hp_prev_q[idx_q]));
					hp_prev_q[idx_q] <= s_q;
					idx_q            <= !idx_q;
					state_q          <= idx_q ? ST_BQ_FB2 : ST_HP_POLE;
				end
				ST_BQ_FB2: begin
					if (mul_done) begin
						t_q     <= mul_res;
						state_q <= ST_BQ_FB1;
					end
				end
				ST_BQ_FB1: begin
					if (mul_done) begin
						t_q     <= sat_state(ext(t_q) + ext(mul_res));
						state_q <= ST_BQ_W;
					end
				end
				ST_BQ_W: begin
					t_q     <= sat_state(ext(s_q) - ext(t_q));
					state_q <= ST_BQ_SUM;
				end
				ST_BQ_SUM: begin
					t_q <= sat_state(ext(t_q) + {{3{dl_q[idx_q][0][SW-1]}}, dl_q[idx_q][0], 1'b0}
						+ ext(dl_q[idx_q][1]));
					dl_q[idx_q][1] <= dl_q[idx_q][0];
					dl_q[idx_q][0] <= t_q;
					state_q        <= ST_BQ_GAIN;
				end
				ST_BQ_GAIN: begin
					if (mul_done) begin
						s_q     <= mul_res;
						idx_q   <= !idx_q;
						state_q <= idx_q ? ST_ROUND : ST_BQ_FB2;
					end
				end
				ST_ROUND: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= rnd_sat;
		end
	end

endmodule

>>> src/abic_mulq.sv
// ----------------------------------------------------------------------------
// abic_mulq: shared rounding state-by-coefficient multiplier
// Forms round(a * c / 2^COEF_FRAC_BITS) saturated to the state width, using
// two partial products; done pulses with the result.
// ----------------------------------------------------------------------------
module abic_mulq #(
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  abic_pkg::state_word_t a,
	input  abic_pkg::coef_t      c,
	output logic                 done,
	output abic_pkg::state_word_t result
);

	localparam int HALF_W = abic_pkg::STATE_W / 2;
	localparam int PROD_W = HALF_W + 1 + abic_pkg::COEF_W;
	localparam int FULL_W = PROD_W + HALF_W;
	localparam int TOP    = abic_pkg::STATE_W - 1 + COEF_FRAC_BITS;
	localparam logic signed [FULL_W-1:0] HALF_LSB =
		{{(FULL_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

	logic signed [HALF_W:0]     lo_a;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [HALF_W-1:0]   ahi_s1;
	abic_pkg::coef_t            c_s1;
	logic signed [FULL_W-1:0]   acc_s2;
	logic signed [FULL_W-1:0]   full;
	logic                       v_s1;
	logic                       v_s2;
	logic                       done_q;
	abic_pkg::state_word_t      res_q;

	assign lo_a = {1'b0, a[HALF_W-1:0]};
	assign full = acc_s2 + {prod_s2, {HALF_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= lo_a * c;
			ahi_s1  <= a[abic_pkg::STATE_W-1:HALF_W];
			c_s1    <= c;
		end
		if (v_s1) begin
			acc_s2  <= {{HALF_W{prod_s1[PROD_W-1]}}, prod_s1} + HALF_LSB;
			prod_s2 <= ahi_s1 * c_s1;
		end
		if (v_s2) begin
			if (full[FULL_W-1:TOP] == {(FULL_W-TOP){full[FULL_W-1]}}) begin
				res_q <= full[TOP:COEF_FRAC_BITS];
			end else if (full[FULL_W-1]) begin
				res_q <= {1'b1, {(abic_pkg::STATE_W-1){1'b0}}};
			end else begin
				res_q <= {1'b0, {(abic_pkg::STATE_W-1){1'b1}}};
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
